/* hdl/rwla_pkg.sv */
// Package for the readers/writers lock arbiter.
// Holds codes, widths, the controller state type and the control/status structs.
// No dependencies.
package rwla_pkg;

    localparam int ID_W            = 4;
    localparam int KIND_W          = 2;
    localparam int CMD_W           = 2;
    localparam int MAP_W           = 16;
    localparam int RDR_W           = 5;
    localparam int DEFAULT_NUM_IDS = 16;

    localparam logic [RDR_W-1:0] READERS_MAX = 5'd31;

    localparam logic [CMD_W-1:0] CMD_START_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END_WRITE   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_HEAD,
        S_LOAD_W,
        S_OUT,
        S_SCAN,
        S_OUT_SCAN
    } state_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_ERROR,
        D_READ,
        D_WRITER,
        D_READERS
    } decision_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load_writer;
        logic scan_step;
    } ctrl_cmd_t;

    typedef struct packed {
        decision_t decision;
        logic      map_pending;
    } dp_status_t;

endpackage

/* hdl/rwla_datapath.sv */
// Datapath of the lock arbiter: request register, lock state, writer queue
// memory, waiting-reader map and result register. Uses rwla_pkg.
module rwla_datapath #(
    parameter int NUM_IDS = rwla_pkg::DEFAULT_NUM_IDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rwla_pkg::ctrl_cmd_t         ctrl,
    output rwla_pkg::dp_status_t        status,
    input  logic [rwla_pkg::CMD_W-1:0]  in_cmd,
    input  logic [rwla_pkg::ID_W-1:0]   in_id,
    output logic [rwla_pkg::ID_W-1:0]   out_id,
    output logic [rwla_pkg::KIND_W-1:0] out_kind,
    output logic                        out_last
);

    localparam int PTR_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W = $clog2(NUM_IDS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_IDS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_IDS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [6:0]       ID_LIMIT = 7'(NUM_IDS);

    logic [rwla_pkg::CMD_W-1:0]  req_cmd_reg;
    logic [rwla_pkg::ID_W-1:0]   req_id_reg;
    logic [rwla_pkg::RDR_W-1:0]  readers_reg, readers_next;
    logic                        writer_active_reg, writer_active_next;
    logic [rwla_pkg::MAP_W-1:0]  wait_map_reg, wait_map_next;
    logic [rwla_pkg::MAP_W-1:0]  queued_map_reg, queued_map_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [rwla_pkg::ID_W-1:0]   head_data_reg;
    logic [rwla_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic [rwla_pkg::KIND_W-1:0] out_kind_reg, out_kind_next;
    logic                        out_last_reg, out_last_next;
    logic [rwla_pkg::ID_W-1:0]   fifo_mem [NUM_IDS];

    rwla_pkg::decision_t         decision;
    logic                        id_bad;
    logic                        lock_free;
    logic                        push;
    logic [rwla_pkg::MAP_W-1:0]  req_bit;
    logic [rwla_pkg::MAP_W-1:0]  scan_bit;
    logic [rwla_pkg::ID_W-1:0]   scan_id;

    assign id_bad    = {3'b000, req_id_reg} >= ID_LIMIT;
    assign lock_free = !writer_active_reg && (count_reg == '0);
    assign req_bit   = rwla_pkg::MAP_W'(1) << req_id_reg;
    assign push      = ctrl.exec && (req_cmd_reg == rwla_pkg::CMD_START_WRITE)
                       && (decision != rwla_pkg::D_ERROR);

    always_comb
    begin
        decision = rwla_pkg::D_NONE;
        if (id_bad)
        begin
            decision = rwla_pkg::D_ERROR;
        end
        else
        begin
            unique case (req_cmd_reg)
                rwla_pkg::CMD_START_READ:
                begin
                    if ((wait_map_reg & req_bit) != '0)
                        decision = rwla_pkg::D_ERROR;
                    else if (lock_free && readers_reg == rwla_pkg::READERS_MAX)
                        decision = rwla_pkg::D_ERROR;
                    else if (lock_free)
                        decision = rwla_pkg::D_READ;
                    else
                        decision = rwla_pkg::D_NONE;
                end
                rwla_pkg::CMD_END_READ:
                begin
                    if (readers_reg == '0)
                        decision = rwla_pkg::D_ERROR;
                    else if (readers_reg == rwla_pkg::RDR_W'(1) && !writer_active_reg
                             && count_reg != '0)
                        decision = rwla_pkg::D_WRITER;
                    else
                        decision = rwla_pkg::D_NONE;
                end
                rwla_pkg::CMD_START_WRITE:
                begin
                    if ((queued_map_reg & req_bit) != '0 || count_reg == CNT_FULL)
                        decision = rwla_pkg::D_ERROR;
                    else if (!writer_active_reg && readers_reg == '0)
                        decision = rwla_pkg::D_WRITER;
                    else
                        decision = rwla_pkg::D_NONE;
                end
                rwla_pkg::CMD_END_WRITE:
                begin
                    if (!writer_active_reg || count_reg == '0 || head_data_reg != req_id_reg)
                        decision = rwla_pkg::D_ERROR;
                    else if (count_reg != CNT_ONE)
                        decision = rwla_pkg::D_WRITER;
                    else if (wait_map_reg != '0)
                        decision = rwla_pkg::D_READERS;
                    else
                        decision = rwla_pkg::D_NONE;
                end
                default:
                begin
                    decision = rwla_pkg::D_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        scan_id = '0;
        for (int i = rwla_pkg::MAP_W - 1; i >= 0; i--)
        begin
            if (wait_map_reg[i])
                scan_id = rwla_pkg::ID_W'(i);
        end
    end

    assign scan_bit = rwla_pkg::MAP_W'(1) << scan_id;

    always_comb
    begin
        readers_next       = readers_reg;
        writer_active_next = writer_active_reg;
        wait_map_next      = wait_map_reg;
        queued_map_next    = queued_map_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        out_id_next        = out_id_reg;
        out_kind_next      = out_kind_reg;
        out_last_next      = out_last_reg;

        if (ctrl.exec)
        begin
            if (decision == rwla_pkg::D_ERROR)
            begin
                out_id_next   = req_id_reg;
                out_kind_next = rwla_pkg::KIND_ERROR;
                out_last_next = 1'b1;
            end
            else
            begin
                unique case (req_cmd_reg)
                    rwla_pkg::CMD_START_READ:
                    begin
                        if (decision == rwla_pkg::D_READ)
                        begin
                            readers_next  = readers_reg + rwla_pkg::RDR_W'(1);
                            out_id_next   = req_id_reg;
                            out_kind_next = rwla_pkg::KIND_READ;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            wait_map_next = wait_map_reg | req_bit;
                        end
                    end
                    rwla_pkg::CMD_END_READ:
                    begin
                        readers_next = readers_reg - rwla_pkg::RDR_W'(1);
                    end
                    rwla_pkg::CMD_START_WRITE:
                    begin
                        queued_map_next = queued_map_reg | req_bit;
                        tail_next       = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                        count_next      = count_reg + CNT_ONE;
                    end
                    rwla_pkg::CMD_END_WRITE:
                    begin
                        writer_active_next = 1'b0;
                        queued_map_next    = queued_map_reg & ~req_bit;
                        head_next          = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                        count_next         = count_reg - CNT_ONE;
                    end
                    default:
                    begin
                        readers_next = readers_reg;
                    end
                endcase
                if (decision == rwla_pkg::D_WRITER)
                    writer_active_next = 1'b1;
            end
        end

        if (ctrl.load_writer)
        begin
            out_id_next   = head_data_reg;
            out_kind_next = rwla_pkg::KIND_WRITE;
            out_last_next = 1'b1;
        end

        if (ctrl.scan_step)
        begin
            if (readers_reg != rwla_pkg::READERS_MAX)
                readers_next = readers_reg + rwla_pkg::RDR_W'(1);
            wait_map_next = wait_map_reg & ~scan_bit;
            out_id_next   = scan_id;
            out_kind_next = rwla_pkg::KIND_READ;
            out_last_next = (wait_map_reg & ~scan_bit) == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readers_reg       <= '0;
            writer_active_reg <= 1'b0;
            wait_map_reg      <= '0;
            queued_map_reg    <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
        end
        else
        begin
            readers_reg       <= readers_next;
            writer_active_reg <= writer_active_next;
            wait_map_reg      <= wait_map_next;
            queued_map_reg    <= queued_map_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            count_reg         <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            req_cmd_reg <= in_cmd;
            req_id_reg  <= in_id;
        end
        out_id_reg   <= out_id_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[tail_reg] <= req_id_reg;
        head_data_reg <= fifo_mem[head_reg];
    end

    assign status.decision    = decision;
    assign status.map_pending = wait_map_reg != '0;
    assign out_id             = out_id_reg;
    assign out_kind           = out_kind_reg;
    assign out_last           = out_last_reg;

    a_writer_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        writer_active_reg |-> count_reg != '0)
        else $error("active writer with an empty queue");

    a_queue_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_map_reg) == int'(count_reg))
        else $error("queued writer map disagrees with queue count");

    a_scan_clears_bit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.scan_step |=> $countones(wait_map_reg) + 1 == $countones($past(wait_map_reg)))
        else $error("reader release did not retire exactly one waiting reader");

endmodule

/* hdl/rwla_ctrl.sv */
// Controller of the lock arbiter: sequences accept, decision, queue-head read,
// reader release and result handoff. Uses rwla_pkg.
module rwla_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rwla_pkg::dp_status_t status,
    output rwla_pkg::ctrl_cmd_t  ctrl
);

    rwla_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwla_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = rwla_pkg::S_DECIDE;
            end
            rwla_pkg::S_DECIDE:
            begin
                unique case (status.decision) inside
                    rwla_pkg::D_ERROR, rwla_pkg::D_READ: state_next = rwla_pkg::S_OUT;
                    rwla_pkg::D_WRITER:                  state_next = rwla_pkg::S_RD_HEAD;
                    rwla_pkg::D_READERS:                 state_next = rwla_pkg::S_SCAN;
                    default:                             state_next = rwla_pkg::S_IDLE;
                endcase
            end
            rwla_pkg::S_RD_HEAD:
            begin
                state_next = rwla_pkg::S_LOAD_W;
            end
            rwla_pkg::S_LOAD_W:
            begin
                state_next = rwla_pkg::S_OUT;
            end
            rwla_pkg::S_OUT:
            begin
                if (out_ready)
                    state_next = rwla_pkg::S_IDLE;
            end
            rwla_pkg::S_SCAN:
            begin
                state_next = rwla_pkg::S_OUT_SCAN;
            end
            rwla_pkg::S_OUT_SCAN:
            begin
                if (out_ready)
                    state_next = status.map_pending ? rwla_pkg::S_SCAN : rwla_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rwla_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        out_valid        = 1'b0;
        ctrl             = '0;
        unique case (state_reg) inside
            rwla_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
            end
            rwla_pkg::S_DECIDE:   ctrl.exec        = 1'b1;
            rwla_pkg::S_LOAD_W:   ctrl.load_writer = 1'b1;
            rwla_pkg::S_SCAN:     ctrl.scan_step   = 1'b1;
            rwla_pkg::S_OUT, rwla_pkg::S_OUT_SCAN: out_valid = 1'b1;
            default:              in_ready         = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rwla_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and result sides open together");

    a_decide_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> ctrl.exec)
        else $error("accepted request not decided in the next cycle");

endmodule

/* hdl/readers_writers_lock_arbiter.sv */
// Top level of the readers/writers lock arbiter with writer priority.
// Instantiates rwla_ctrl and rwla_datapath; uses rwla_pkg.
//
// One request is handled at a time. A request that yields no grant goes
// through accept and decision only; an error or immediate read grant then
// goes to the result state; a writer grant first reads and loads the queue
// head (a registered memory read). Waiting readers released after the last
// writer leaves come out one result per scan step, in ascending id order.
// Each result is held on m_tdata and m_tuser until its transfer.
module readers_writers_lock_arbiter #(
    parameter int NUM_IDS = rwla_pkg::DEFAULT_NUM_IDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [3:0] requester_id, [7:4] zero
    input  logic [rwla_pkg::CMD_W-1:0]  s_tuser,   // [1:0] cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [3:0] granted_id, [7:4] zero
    output logic [rwla_pkg::KIND_W-1:0] m_tuser,   // [1:0] grant_kind
    output logic                        m_tlast
);

    rwla_pkg::ctrl_cmd_t         ctrl;
    rwla_pkg::dp_status_t        status;
    logic [rwla_pkg::ID_W-1:0]   out_id;
    logic [rwla_pkg::KIND_W-1:0] out_kind;

    rwla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .ctrl      (ctrl)
    );

    rwla_datapath #(
        .NUM_IDS (NUM_IDS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .status   (status),
        .in_cmd   (s_tuser),
        .in_id    (s_tdata[3:0]),
        .out_id   (out_id),
        .out_kind (out_kind),
        .out_last (m_tlast)
    );

    assign m_tdata = {4'b0000, out_id};
    assign m_tuser = out_kind;

endmodule

/* bench/rwla_checker.sv */
// Checker for readers_writers_lock_arbiter: watches both stream channels,
// predicts the grants of each accepted request and compares them in order.
// Depends on rwla_pkg.
module rwla_checker #(
    parameter int NUM_IDS = rwla_pkg::DEFAULT_NUM_IDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [3:0] requester_id, [7:4] zero
    input  logic [rwla_pkg::CMD_W-1:0]  s_tuser,   // [1:0] cmd
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,   // [3:0] granted_id, [7:4] zero
    input  logic [rwla_pkg::KIND_W-1:0] m_tuser,   // [1:0] grant_kind
    input  logic                        m_tlast,
    output int unsigned                 fail_count,
    output int unsigned                 grants_owed,
    output int unsigned                 requests_seen,
    output int unsigned                 grants_seen,
    output int unsigned                 errors_seen,
    output int unsigned                 longest_release
);

    localparam int DUE_DEPTH = 64;

    typedef struct {
        logic [rwla_pkg::ID_W-1:0]   id;
        logic [rwla_pkg::KIND_W-1:0] kind;
        logic                        last;
    } grant_t;

    grant_t                      due_ring [DUE_DEPTH];
    int                          due_rd;
    int                          due_wr;
    int                          due_cnt;

    logic [rwla_pkg::RDR_W-1:0]  readers_cnt;
    logic                        writer_holds;
    logic [NUM_IDS-1:0]          parked_map;
    logic [rwla_pkg::ID_W-1:0]   wr_ring [NUM_IDS];
    int                          wr_head;
    int                          wr_tail;
    int                          wr_cnt;

    task automatic post_grant(input logic [rwla_pkg::ID_W-1:0] id,
                              input logic [rwla_pkg::KIND_W-1:0] kind);
        if (due_cnt == DUE_DEPTH)
        begin
            $error("expected grant list overflow at granted_id %0d", id);
            fail_count++;
            return;
        end
        due_ring[due_wr].id   = id;
        due_ring[due_wr].kind = kind;
        due_ring[due_wr].last = 1'b0;
        due_wr = (due_wr + 1) % DUE_DEPTH;
        due_cnt++;
    endtask

    function automatic bit writer_listed(input logic [rwla_pkg::ID_W-1:0] id);
        for (int i = 0; i < wr_cnt; i++)
            if (wr_ring[(wr_head + i) % NUM_IDS] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic grant_head_writer(inout int n);
        if (!writer_holds && readers_cnt == '0 && wr_cnt > 0)
        begin
            writer_holds = 1'b1;
            post_grant(wr_ring[wr_head], rwla_pkg::KIND_WRITE);
            n++;
        end
    endtask

    task automatic predict_request(input logic [rwla_pkg::CMD_W-1:0] cmd,
                                   input logic [rwla_pkg::ID_W-1:0] id);
        int     n;
        bit     bad;
        n   = 0;
        bad = 1'b0;
        if (int'(id) >= NUM_IDS)
            bad = 1'b1;
        else
            case (cmd)
                rwla_pkg::CMD_START_READ:
                    if (parked_map[id])
                        bad = 1'b1;
                    else if (!writer_holds && wr_cnt == 0)
                    begin
                        if (readers_cnt == rwla_pkg::READERS_MAX)
                            bad = 1'b1;
                        else
                        begin
                            readers_cnt++;
                            post_grant(id, rwla_pkg::KIND_READ);
                            n = 1;
                        end
                    end
                    else
                        parked_map[id] = 1'b1;
                rwla_pkg::CMD_END_READ:
                    if (readers_cnt == '0)
                        bad = 1'b1;
                    else
                    begin
                        readers_cnt--;
                        grant_head_writer(n);
                    end
                rwla_pkg::CMD_START_WRITE:
                    if (writer_listed(id) || wr_cnt >= NUM_IDS)
                        bad = 1'b1;
                    else
                    begin
                        wr_ring[wr_tail] = id;
                        wr_tail = (wr_tail + 1) % NUM_IDS;
                        wr_cnt++;
                        grant_head_writer(n);
                    end
                default:
                    if (!writer_holds || wr_cnt == 0 || wr_ring[wr_head] != id)
                        bad = 1'b1;
                    else
                    begin
                        writer_holds = 1'b0;
                        wr_head = (wr_head + 1) % NUM_IDS;
                        wr_cnt--;
                        if (wr_cnt > 0)
                            grant_head_writer(n);
                        else
                        begin
                            // wake every parked reader, lowest id first
                            for (int i = 0; i < NUM_IDS; i++)
                                if (parked_map[i])
                                begin
                                    if (readers_cnt != rwla_pkg::READERS_MAX)
                                        readers_cnt++;
                                    post_grant(rwla_pkg::ID_W'(i), rwla_pkg::KIND_READ);
                                    n++;
                                end
                            parked_map = '0;
                        end
                    end
            endcase
        if (bad)
        begin
            post_grant(id, rwla_pkg::KIND_ERROR);
            n = 1;
        end
        if (n > 0 && due_cnt > 0)
            due_ring[(due_wr + DUE_DEPTH - 1) % DUE_DEPTH].last = 1'b1;
        if (n > longest_release)
            longest_release = n;
    endtask

    task automatic check_grant();
        grant_t want;
        grants_seen++;
        if (m_tuser == rwla_pkg::KIND_ERROR)
            errors_seen++;
        if (due_cnt == 0)
        begin
            $error("unexpected transfer: granted_id %0d grant_kind %0d last %0b",
                   m_tdata[3:0], m_tuser, m_tlast);
            fail_count++;
        end
        else
        begin
            want   = due_ring[due_rd];
            due_rd = (due_rd + 1) % DUE_DEPTH;
            due_cnt--;
            if (m_tdata[3:0] != want.id)
            begin
                $error("granted_id: expected %0d, got %0d", want.id, m_tdata[3:0]);
                fail_count++;
            end
            if (m_tuser != want.kind)
            begin
                $error("grant_kind: expected %0d, got %0d", want.kind, m_tuser);
                fail_count++;
            end
            if (m_tlast != want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, m_tlast);
                fail_count++;
            end
            if (m_tdata[7:4] != 4'b0000)
            begin
                $error("pad: expected 0, got %0d", m_tdata[7:4]);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readers_cnt     = '0;
            writer_holds    = 1'b0;
            parked_map      = '0;
            wr_head         = 0;
            wr_tail         = 0;
            wr_cnt          = 0;
            due_rd          = 0;
            due_wr          = 0;
            due_cnt         = 0;
            fail_count      = 0;
            requests_seen   = 0;
            grants_seen     = 0;
            errors_seen     = 0;
            longest_release = 0;
            grants_owed <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                requests_seen++;
                predict_request(s_tuser, s_tdata[3:0]);
            end
            if (m_tvalid && m_tready)
                check_grant();
            grants_owed <= $unsigned(due_cnt);
        end
    end

endmodule

/* bench/tb.sv */
// Testbench top for readers_writers_lock_arbiter: drives lock requests with
// random gaps and output stalls and gives the verdict.
// Depends on rwla_pkg, rwla_checker and the block's RTL.
module tb;

    localparam int NUM_IDS       = rwla_pkg::DEFAULT_NUM_IDS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = 8'h00;  // [3:0] requester_id, [7:4] zero
    logic [rwla_pkg::CMD_W-1:0]  s_tuser  = '0;     // [1:0] cmd
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;           // [3:0] granted_id, [7:4] zero
    logic [rwla_pkg::KIND_W-1:0] m_tuser;           // [1:0] grant_kind
    logic                        m_tlast;

    int unsigned fail_count;
    int unsigned grants_owed;
    int unsigned requests_seen;
    int unsigned grants_seen;
    int unsigned errors_seen;
    int unsigned longest_release;

    // stimulus steering: what the lock holds after the requests sent so far
    int                          held_reads = 0;
    logic [NUM_IDS-1:0]          parked     = '0;
    logic [rwla_pkg::ID_W-1:0]   line_ids [NUM_IDS];
    int                          line_head  = 0;
    int                          line_cnt   = 0;

    bit          calm       = 1'b0;
    int          stall_left = 0;
    int unsigned cycles     = 0;

    always #2 clk = ~clk;

    readers_writers_lock_arbiter #(.NUM_IDS(NUM_IDS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rwla_checker #(.NUM_IDS(NUM_IDS)) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .grants_owed     (grants_owed),
        .requests_seen   (requests_seen),
        .grants_seen     (grants_seen),
        .errors_seen     (errors_seen),
        .longest_release (longest_release)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit in_line(input logic [rwla_pkg::ID_W-1:0] id);
        for (int i = 0; i < line_cnt; i++)
            if (line_ids[(line_head + i) % NUM_IDS] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void track(input logic [rwla_pkg::CMD_W-1:0] cmd,
                                  input logic [rwla_pkg::ID_W-1:0] id);
        case (cmd)
            rwla_pkg::CMD_START_READ:
                if (!parked[id])
                begin
                    if (line_cnt != 0)
                        parked[id] = 1'b1;
                    else if (held_reads < int'(rwla_pkg::READERS_MAX))
                        held_reads++;
                end
            rwla_pkg::CMD_END_READ:
                if (held_reads > 0)
                    held_reads--;
            rwla_pkg::CMD_START_WRITE:
                if (!in_line(id) && line_cnt < NUM_IDS)
                begin
                    line_ids[(line_head + line_cnt) % NUM_IDS] = id;
                    line_cnt++;
                end
            default:
                if (line_cnt != 0 && held_reads == 0 && line_ids[line_head] == id)
                begin
                    line_head = (line_head + 1) % NUM_IDS;
                    line_cnt--;
                    if (line_cnt == 0)
                    begin
                        held_reads += $countones(parked);
                        parked = '0;
                    end
                end
        endcase
    endfunction

    task automatic sender_gap();
        int n;
        if (calm || $urandom_range(0, 99) < 60)
            return;
        n = gap_len();
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        s_tuser  <= rwla_pkg::CMD_W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    task automatic send(input logic [rwla_pkg::CMD_W-1:0] cmd,
                        input logic [rwla_pkg::ID_W-1:0] id);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, id};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track(cmd, id);
        sender_gap();
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (grants_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // release everything the lock holds, readers first
    task automatic settle();
        while (held_reads > 0 || line_cnt != 0)
        begin
            if (held_reads > 0)
                send(rwla_pkg::CMD_END_READ, rwla_pkg::ID_W'($urandom));
            else
                send(rwla_pkg::CMD_END_WRITE, line_ids[line_head]);
        end
    endtask

    // leaves every reader holding the lock
    task automatic release_every_reader();
        logic [rwla_pkg::ID_W-1:0] w;
        settle();
        w = rwla_pkg::ID_W'($urandom);
        send(rwla_pkg::CMD_START_WRITE, w);
        for (int i = NUM_IDS - 1; i >= 0; i--)
            send(rwla_pkg::CMD_START_READ, rwla_pkg::ID_W'(i));
        send(rwla_pkg::CMD_END_WRITE, w);
    endtask

    // expects no writer in line; sends reads up to one past a full reader count, then releases all
    task automatic fill_reader_count();
        int n;
        n = int'(rwla_pkg::READERS_MAX) + 1 - held_reads;
        repeat (n)
            send(rwla_pkg::CMD_START_READ, rwla_pkg::ID_W'($urandom));
        settle();
    endtask

    task automatic random_request();
        int                         pick;
        logic [rwla_pkg::CMD_W-1:0] cmd;
        logic [rwla_pkg::ID_W-1:0]  id;
        if ($urandom_range(0, 99) < 15)
        begin
            send(rwla_pkg::CMD_W'($urandom), rwla_pkg::ID_W'($urandom));
            return;
        end
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if (parked != '1 &&
                    !(line_cnt == 0 && held_reads >= int'(rwla_pkg::READERS_MAX)))
                begin
                    cmd = rwla_pkg::CMD_START_READ;
                    break;
                end
            end
            else if (pick < 55)
            begin
                if (held_reads > 0)
                begin
                    cmd = rwla_pkg::CMD_END_READ;
                    break;
                end
            end
            else if (pick < 75)
            begin
                if (line_cnt < NUM_IDS)
                begin
                    cmd = rwla_pkg::CMD_START_WRITE;
                    break;
                end
            end
            else if (line_cnt != 0 && held_reads == 0)
            begin
                cmd = rwla_pkg::CMD_END_WRITE;
                break;
            end
        end
        case (cmd)
            rwla_pkg::CMD_START_READ:
                do id = rwla_pkg::ID_W'($urandom); while (parked[id]);
            rwla_pkg::CMD_START_WRITE:
                do id = rwla_pkg::ID_W'($urandom); while (in_line(id));
            rwla_pkg::CMD_END_WRITE:
                id = line_ids[line_head];
            default:
                id = rwla_pkg::ID_W'($urandom);
        endcase
        send(cmd, id);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && rst_n && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d grants still owed", cycles, grants_owed);
            $display("** readers_writers_lock_arbiter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // unmatched ends, immediate grants, queued writer, duplicates, handovers
        send(rwla_pkg::CMD_END_READ, 4'd0);
        send(rwla_pkg::CMD_END_WRITE, 4'd5);
        send(rwla_pkg::CMD_START_READ, 4'd0);
        send(rwla_pkg::CMD_START_READ, 4'd15);
        send(rwla_pkg::CMD_START_WRITE, 4'd3);
        send(rwla_pkg::CMD_START_WRITE, 4'd3);
        send(rwla_pkg::CMD_START_READ, 4'd7);
        send(rwla_pkg::CMD_START_READ, 4'd7);
        send(rwla_pkg::CMD_START_READ, 4'd2);
        send(rwla_pkg::CMD_END_WRITE, 4'd3);
        send(rwla_pkg::CMD_END_READ, 4'd0);
        send(rwla_pkg::CMD_END_READ, 4'd15);
        send(rwla_pkg::CMD_START_WRITE, 4'd12);
        send(rwla_pkg::CMD_END_WRITE, 4'd12);
        send(rwla_pkg::CMD_END_WRITE, 4'd3);
        send(rwla_pkg::CMD_START_READ, 4'd0);
        send(rwla_pkg::CMD_END_WRITE, 4'd12);
        send(rwla_pkg::CMD_END_READ, 4'd9);
        send(rwla_pkg::CMD_END_READ, 4'd9);
        send(rwla_pkg::CMD_END_READ, 4'd9);
        send(rwla_pkg::CMD_START_WRITE, 4'd15);
        send(rwla_pkg::CMD_START_READ, 4'd15);
        send(rwla_pkg::CMD_END_WRITE, 4'd15);
        settle();

        release_every_reader();
        fill_reader_count();

        for (int i = 0; i < 10; i++)
        begin
            calm = (i >= 4 && i < 8);
            random_request();
        end
        calm = 1'b0;
        quiesce();
        for (int i = 0; i < 6; i++)
            random_request();
        settle();
        quiesce();

        $display("covered %0d requests and %0d grants, %0d of them protocol errors;",
                 requests_seen, grants_seen, errors_seen);
        $display("largest burst from one request: %0d grants", longest_release);
        if (fail_count == 0)
            $display("** readers_writers_lock_arbiter: PASSED **");
        else
            $display("** readers_writers_lock_arbiter: FAILED **");
        $finish;
    end

endmodule
